// File: sv/gcpm_pkg.sv
package gcpm_pkg;

  localparam int COEF_WIDTH = 40;
  localparam int OUT_WIDTH = 16;
  localparam int POS_W = 16;
  localparam int DW = POS_W + 1;
  localparam int MONO_W = 3 * DW;
  localparam int NUM_TERMS = 10;
  localparam int NUM_POLYS = 4;
  localparam int NUM_SLOTS = NUM_TERMS * NUM_POLYS;
  localparam int SLOT_IDX_W = 6;
  localparam int LIMIT_W = 15;
  localparam int FRAC = 32;
  localparam int CL_W = COEF_WIDTH / 2;
  localparam int CH_W = COEF_WIDTH - CL_W;
  localparam int ML_W = (MONO_W + 1) / 2;
  localparam int MH_W = MONO_W - ML_W;
  localparam int PROD_W = COEF_WIDTH + MONO_W;
  localparam int ACC_W = PROD_W + 4;
  localparam int TOP_W = ACC_W - FRAC - OUT_WIDTH + 1;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int POLY_LAT = 6;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_LEFT_CX = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_CY = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_CX = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_CY = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_Y = 3'd5;

  localparam logic [LIMIT_W-1:0] LIMIT_X_RESET = 15'd960;
  localparam logic [LIMIT_W-1:0] LIMIT_Y_RESET = 15'd540;

  localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH - 1){1'b1}}};
  localparam logic [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH - 1){1'b0}}};

  typedef struct packed {
    logic                         cmd;
    logic [SLOT_IDX_W-1:0]        coef_index;
    logic signed [COEF_WIDTH-1:0] coef_value;
    logic [POS_W-1:0]             left_x;
    logic [POS_W-1:0]             left_y;
    logic [POS_W-1:0]             right_x;
    logic [POS_W-1:0]             right_y;
  } item_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] left_disp_x;
    logic signed [OUT_WIDTH-1:0] left_disp_y;
    logic signed [OUT_WIDTH-1:0] right_disp_x;
    logic signed [OUT_WIDTH-1:0] right_disp_y;
    logic                        in_display;
    logic                        saturated;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0] left_cx;
    logic [POS_W-1:0] left_cy;
    logic [POS_W-1:0] right_cx;
    logic [POS_W-1:0] right_cy;
  } centers_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] x;
    logic [LIMIT_W-1:0] y;
  } limits_t;

  typedef struct packed {
    logic                         is_map;
    logic [SLOT_IDX_W-1:0]        coef_index;
    logic [COEF_WIDTH-1:0]        coef_value;
    logic signed [DW-1:0]         ldx;
    logic signed [DW-1:0]         ldy;
    logic signed [DW-1:0]         rdx;
    logic signed [DW-1:0]         rdy;
  } q_entry_t;

  typedef logic [NUM_TERMS-1:0][MONO_W-1:0] mono_vec_t;
  typedef logic [NUM_TERMS-1:0][COEF_WIDTH-1:0] coef_vec_t;

  // Magnitude of a two's complement output; the most negative code gives 2^(OUT_WIDTH-1).
  function automatic logic [OUT_WIDTH:0] out_mag(input logic [OUT_WIDTH-1:0] v);
    logic [OUT_WIDTH:0] ext;
    ext = {v[OUT_WIDTH-1], v};
    return v[OUT_WIDTH-1] ? (~ext + 1'b1) : ext;
  endfunction

endpackage

// File: sv/gcpm_front.sv
module gcpm_front import gcpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  item_t    item,
  input  centers_t centers,
  output logic     qi_valid,
  input  logic     qi_ready,
  output q_entry_t qi_entry
);

  logic     f_valid;
  q_entry_t f_entry;
  logic     take;
  logic     keep;

  assign item_ready = !f_valid || qi_ready;
  assign take = item_valid && item_ready;
  // Loads aimed past the last slot are taken and dropped here.
  assign keep = (item.cmd == CMD_MAP) || (item.coef_index < SLOT_IDX_W'(NUM_SLOTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take && keep) begin
      f_valid <= 1'b1;
    end else if (qi_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && keep) begin
      f_entry.is_map     <= (item.cmd == CMD_MAP);
      f_entry.coef_index <= item.coef_index;
      f_entry.coef_value <= item.coef_value;
      f_entry.ldx <= $signed({1'b0, item.left_x}) - $signed({1'b0, centers.left_cx});
      f_entry.ldy <= $signed({1'b0, item.left_y}) - $signed({1'b0, centers.left_cy});
      f_entry.rdx <= $signed({1'b0, item.right_x}) - $signed({1'b0, centers.right_cx});
      f_entry.rdy <= $signed({1'b0, item.right_y}) - $signed({1'b0, centers.right_cy});
    end
  end

  assign qi_valid = f_valid;
  assign qi_entry = f_entry;

endmodule

// File: sv/gcpm_queue.sv
module gcpm_queue import gcpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     qi_valid,
  output logic     qi_ready,
  input  q_entry_t qi_entry,
  output logic     qo_valid,
  input  logic     qo_pop,
  output q_entry_t qo_entry
);

  q_entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                pop;

  assign qi_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign qo_valid = (count != '0);
  assign push = qi_valid && qi_ready;
  assign pop = qo_pop && qo_valid;
  assign qo_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= qi_entry;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + QCNT_W'(1))
    else $error("queue count did not rise on a lone push");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - QCNT_W'(1))
    else $error("queue count did not fall on a lone pop");
  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count passed its depth");
`endif

endmodule

// File: sv/gcpm_poly.sv
module gcpm_poly import gcpm_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  mono_vec_t            mono,
  input  coef_vec_t            coef,
  output logic [OUT_WIDTH-1:0] value,
  output logic                 sat
);

  logic [CL_W-1:0]                cl [NUM_TERMS];
  logic signed [CH_W-1:0]         ch [NUM_TERMS];
  logic [ML_W-1:0]                ml [NUM_TERMS];
  logic signed [MH_W-1:0]         mh [NUM_TERMS];

  logic [CL_W+ML_W-1:0]           pp_ll [NUM_TERMS];
  logic signed [CL_W+MH_W:0]      pp_lh [NUM_TERMS];
  logic signed [CH_W+ML_W:0]      pp_hl [NUM_TERMS];
  logic signed [CH_W+MH_W-1:0]    pp_hh [NUM_TERMS];

  logic [PROD_W-1:0]              prod [NUM_TERMS];
  logic [ACC_W-1:0]               pair [NUM_TERMS/2];
  logic [ACC_W-1:0]               part [3];
  logic [ACC_W-1:0]               total;
  logic [TOP_W-1:0]               top;
  logic                           fits;

  // Both operands are split in halves so that each partial product stays narrow.
  always_comb begin
    for (int t = 0; t < NUM_TERMS; t++) begin
      cl[t] = coef[t][CL_W-1:0];
      ch[t] = $signed(coef[t][COEF_WIDTH-1:CL_W]);
      ml[t] = mono[t][ML_W-1:0];
      mh[t] = $signed(mono[t][MONO_W-1:ML_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < NUM_TERMS; t++) begin
        pp_ll[t] <= cl[t] * ml[t];
        pp_lh[t] <= $signed({1'b0, cl[t]}) * mh[t];
        pp_hl[t] <= ch[t] * $signed({1'b0, ml[t]});
        pp_hh[t] <= ch[t] * mh[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < NUM_TERMS; t++) begin
        prod[t] <= (PROD_W'(pp_hh[t]) << (CL_W + ML_W)) + (PROD_W'(pp_lh[t]) << ML_W)
                 + (PROD_W'(pp_hl[t]) << CL_W) + PROD_W'(pp_ll[t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_TERMS / 2; i++) begin
        pair[i] <= ACC_W'($signed(prod[2*i])) + ACC_W'($signed(prod[2*i+1]));
      end
      part[0] <= pair[0] + pair[1];
      part[1] <= pair[2] + pair[3];
      part[2] <= pair[4];
      total <= part[0] + part[1] + part[2];
    end
  end

  // The sum carries 32 fractional bits; it fits when every bit above the kept field matches.
  always_comb begin
    top = total[ACC_W-1:FRAC+OUT_WIDTH-1];
    fits = (&top) || !(|top);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= !fits;
      if (fits) begin
        value <= total[FRAC+OUT_WIDTH-1:FRAC];
      end else if (total[ACC_W-1]) begin
        value <= OUT_MIN;
      end else begin
        value <= OUT_MAX;
      end
    end
  end

endmodule

// File: sv/gcpm_back.sv
module gcpm_back import gcpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     qo_valid,
  output logic     qo_pop,
  input  q_entry_t qo_entry,
  input  limits_t  limits,
  output logic     result_valid,
  input  logic     result_ready,
  output result_t  result
);

  logic                         en;
  logic                         s1_valid;
  logic                         s1_map;
  logic [SLOT_IDX_W-1:0]        s1_index;
  logic [COEF_WIDTH-1:0]        s1_value;
  logic signed [DW-1:0]         s1_dx [2];
  logic signed [DW-1:0]         s1_dy [2];
  logic signed [2*DW-1:0]       s1_x2 [2];
  logic signed [2*DW-1:0]       s1_y2 [2];
  logic signed [2*DW-1:0]       s1_xy [2];

  logic                         s2_valid;
  logic                         s2_map;
  logic [SLOT_IDX_W-1:0]        s2_index;
  logic [COEF_WIDTH-1:0]        s2_value;
  mono_vec_t                    s2_mono [2];

  logic [NUM_SLOTS-1:0][COEF_WIDTH-1:0] coef;
  logic [POLY_LAT-1:0]          vpipe;
  logic [OUT_WIDTH-1:0]         pval [NUM_POLYS];
  logic [NUM_POLYS-1:0]         psat;

  // The whole back end advances together unless a finished result is held.
  assign en = !result_valid || result_ready;
  assign qo_pop = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      vpipe <= '0;
      result_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= qo_valid;
      s2_valid <= s1_valid;
      vpipe <= {vpipe[POLY_LAT-2:0], s2_valid && s2_map};
      result_valid <= vpipe[POLY_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_map <= qo_entry.is_map;
      s1_index <= qo_entry.coef_index;
      s1_value <= qo_entry.coef_value;
      s1_dx[0] <= qo_entry.ldx;
      s1_dy[0] <= qo_entry.ldy;
      s1_dx[1] <= qo_entry.rdx;
      s1_dy[1] <= qo_entry.rdy;
      s1_x2[0] <= qo_entry.ldx * qo_entry.ldx;
      s1_y2[0] <= qo_entry.ldy * qo_entry.ldy;
      s1_xy[0] <= qo_entry.ldx * qo_entry.ldy;
      s1_x2[1] <= qo_entry.rdx * qo_entry.rdx;
      s1_y2[1] <= qo_entry.rdy * qo_entry.rdy;
      s1_xy[1] <= qo_entry.rdx * qo_entry.rdy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_map <= s1_map;
      s2_index <= s1_index;
      s2_value <= s1_value;
      for (int e = 0; e < 2; e++) begin
        s2_mono[e][0] <= s1_x2[e] * s1_dx[e];
        s2_mono[e][1] <= s1_x2[e] * s1_dy[e];
        s2_mono[e][2] <= s1_y2[e] * s1_dx[e];
        s2_mono[e][3] <= s1_y2[e] * s1_dy[e];
        s2_mono[e][4] <= MONO_W'(s1_x2[e]);
        s2_mono[e][5] <= MONO_W'(s1_xy[e]);
        s2_mono[e][6] <= MONO_W'(s1_y2[e]);
        s2_mono[e][7] <= MONO_W'(s1_dx[e]);
        s2_mono[e][8] <= MONO_W'(s1_dy[e]);
        s2_mono[e][9] <= MONO_W'(1);
      end
    end
  end

  // Loads write at the same point where samples read the table, so program order holds.
  always_ff @(posedge clk) begin
    if (en && s2_valid && !s2_map) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (s2_index == SLOT_IDX_W'(i)) begin
          coef[i] <= s2_value;
        end
      end
    end
  end

  for (genvar p = 0; p < NUM_POLYS; p++) begin : g_poly
    gcpm_poly u_poly (
      .clk   (clk),
      .en    (en),
      .mono  (s2_mono[p/2]),
      .coef  (coef[p*NUM_TERMS +: NUM_TERMS]),
      .value (pval[p]),
      .sat   (psat[p])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.left_disp_x <= pval[0];
      result.left_disp_y <= pval[1];
      result.right_disp_x <= pval[2];
      result.right_disp_y <= pval[3];
      result.in_display <= (32'(out_mag(pval[0])) <= 32'(limits.x))
                        && (32'(out_mag(pval[1])) <= 32'(limits.y))
                        && (32'(out_mag(pval[2])) <= 32'(limits.x))
                        && (32'(out_mag(pval[3])) <= 32'(limits.y));
      result.saturated <= |psat;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_map && en |=> !vpipe[0])
    else $error("coefficient load entered the result pipeline");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vpipe) && $stable(s2_valid) && $stable(s1_valid))
    else $error("pipeline moved while stalled");
  a_reach_out: assert property (@(posedge clk) disable iff (rst)
    en && vpipe[POLY_LAT-1] |=> result_valid)
    else $error("finished sample did not reach the output register");
`endif

endmodule

// File: sv/gaze_cubic_poly_mapper.sv
// Gaze mapper: turns a pair of pupil positions into display coordinates
// with four bivariate cubic polynomials (left x, left y, right x, right y).
// Items enter on item_valid/item_ready. A load item (cmd 0) writes one
// coefficient and gives no result; a map item (cmd 1) gives one result on
// result_valid/result_ready. Items are processed strictly in order, so a map
// sees every load that came before it. Every coefficient a map uses must
// have been loaded first; the table is not cleared by reset.
// Throughput is one item per cycle while the receiver is ready. A map item's
// result passes through a front register, the queue, two monomial stages,
// the six-stage multiply and adder tree and the output register.
// Reset empties the pipeline and sets the centers to 0 and the display
// limits to 960 and 540. Configuration writes through cfg_we take effect at
// once; the user must make them while no item is in flight; nothing enforces it.
// When the receiver stalls, the back pipeline holds in place; the queue and
// front register take up to three more items before item_ready falls.
module gaze_cubic_poly_mapper import gcpm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  centers_t centers;
  limits_t  limits;
  logic     qi_valid;
  logic     qi_ready;
  q_entry_t qi_entry;
  logic     qo_valid;
  logic     qo_pop;
  q_entry_t qo_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      centers <= '0;
      limits.x <= LIMIT_X_RESET;
      limits.y <= LIMIT_Y_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_CX:  centers.left_cx <= cfg_data[POS_W-1:0];
        REG_LEFT_CY:  centers.left_cy <= cfg_data[POS_W-1:0];
        REG_RIGHT_CX: centers.right_cx <= cfg_data[POS_W-1:0];
        REG_RIGHT_CY: centers.right_cy <= cfg_data[POS_W-1:0];
        REG_LIMIT_X:  limits.x <= cfg_data[LIMIT_W-1:0];
        REG_LIMIT_Y:  limits.y <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gcpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .centers    (centers),
    .qi_valid   (qi_valid),
    .qi_ready   (qi_ready),
    .qi_entry   (qi_entry)
  );

  gcpm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .qi_valid (qi_valid),
    .qi_ready (qi_ready),
    .qi_entry (qi_entry),
    .qo_valid (qo_valid),
    .qo_pop   (qo_pop),
    .qo_entry (qo_entry)
  );

  gcpm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qo_valid     (qo_valid),
    .qo_pop       (qo_pop),
    .qo_entry     (qo_entry),
    .limits       (limits),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
